>>> sv/dds_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dds_pkg
// Shared types, codes and default sizes for the DDS waveform generator.
// ----------------------------------------------------------------------------
package dds_pkg;

    // default sizes
    localparam int DEF_TABLE_DEPTH       = 1024;
    localparam int DEF_SHORT_TABLE_DEPTH = 256;
    localparam int DEF_FRACTION_BITS     = 10;
    localparam int DEF_PHASE_BITS        = 32;

    // fixed field widths
    localparam int ENTRY_W    = 10;
    localparam int VALUE_W    = 16;
    localparam int SAMPLE_W   = 16;
    localparam int INC_W      = 32;
    localparam int AMP_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // item operations
    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_WRITE  = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    // resolution modes, also the table kind of a write item
    typedef enum logic [1:0] {
        RES_SHORT  = 2'd0,
        RES_NARROW = 2'd1,
        RES_WIDE   = 2'd2
    } t_res;

    typedef enum logic [1:0] {
        INTERP_OFF  = 2'd0,
        INTERP_LIN  = 2'd1,
        INTERP_QUAD = 2'd2
    } t_interp;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHASE_INC = 3'd0,
        REG_AMPLITUDE = 3'd1,
        REG_WAVEFORM  = 3'd2,
        REG_RES_MODE  = 3'd3,
        REG_INTERP    = 3'd4
    } t_reg;

    // controller to datapath
    typedef struct packed {
        logic       step;
        logic       write_entry;
        logic       clear_phase;
        logic       cfg_write;
        logic [1:0] rd_off;
        logic       cap_p0;
        logic       cap_p1;
        logic       cap_p2;
        logic       mul1;
        logic       mul2;
        logic       sum;
        logic       load_out;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage
`default_nettype wire

>>> sv/dds_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dds_ctrl
// Sequencer: accepts items and config writes, then walks a sample item
// through the three table reads, the multiplies, the sum and the scaling.
// ----------------------------------------------------------------------------
module dds_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_operation,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  dds_pkg::t_dp_stat  i_stat,
    output dds_pkg::t_dp_cmd   o_cmd
);
    import dds_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RD0   = 9'b000000010,
        S_RD1   = 9'b000000100,
        S_RD2   = 9'b000001000,
        S_RD3   = 9'b000010000,
        S_MUL1  = 9'b000100000,
        S_MUL2  = 9'b001000000,
        S_SUM   = 9'b010000000,
        S_SCALE = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    // hold items off while a register write is waiting
    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.cfg_write = i_cfg_valid;
                if (w_accept) begin
                    case (i_operation)
                        OP_SAMPLE: begin
                            o_cmd.step = 1'b1;
                            n_state    = S_RD0;
                        end
                        OP_WRITE: o_cmd.write_entry = 1'b1;
                        OP_CLEAR: o_cmd.clear_phase = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_RD0: begin
                o_cmd.rd_off = 2'd0;
                n_state      = S_RD1;
            end
            S_RD1: begin
                o_cmd.rd_off = 2'd1;
                o_cmd.cap_p0 = 1'b1;
                n_state      = S_RD2;
            end
            S_RD2: begin
                o_cmd.rd_off = 2'd2;
                o_cmd.cap_p1 = 1'b1;
                n_state      = S_RD3;
            end
            S_RD3: begin
                o_cmd.cap_p2 = 1'b1;
                n_state      = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_SCALE;
            end
            S_SCALE: begin
                // hold until the output register is free
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

>>> sv/dds_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dds_dp
// Datapath: configuration registers, phase accumulator, wave table memories,
// interpolation arithmetic, amplitude scaling and the output register.
// ----------------------------------------------------------------------------
module dds_dp #(
    parameter int TABLE_DEPTH       = dds_pkg::DEF_TABLE_DEPTH,
    parameter int SHORT_TABLE_DEPTH = dds_pkg::DEF_SHORT_TABLE_DEPTH,
    parameter int FRACTION_BITS     = dds_pkg::DEF_FRACTION_BITS,
    parameter int PHASE_BITS        = dds_pkg::DEF_PHASE_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dds_pkg::t_dp_cmd                 i_cmd,
    output dds_pkg::t_dp_stat                o_stat,
    input  logic [1:0]                       i_table_kind,
    input  logic [1:0]                       i_wave_index,
    input  logic [dds_pkg::ENTRY_W-1:0]      i_entry_index,
    input  logic [dds_pkg::VALUE_W-1:0]      i_entry_value,
    input  logic [dds_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dds_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [dds_pkg::SAMPLE_W-1:0]     o_sample
);
    import dds_pkg::*;

    localparam int IDX_BITS  = $clog2(TABLE_DEPTH);
    localparam int SIDX_BITS = $clog2(SHORT_TABLE_DEPTH);
    localparam int F         = FRACTION_BITS;
    localparam int P_W       = VALUE_W + 1;            // table value as signed
    localparam int D2_W      = VALUE_W + 2;            // second difference
    localparam int M1_W      = P_W + F + 1;
    localparam int M2_W      = D2_W + F + 1;
    localparam int Y_W       = VALUE_W + 4;
    localparam logic [IDX_BITS:0]  DEPTH_L  = (IDX_BITS + 1)'(TABLE_DEPTH);
    localparam logic [SIDX_BITS:0] SDEPTH_L = (SIDX_BITS + 1)'(SHORT_TABLE_DEPTH);
    localparam logic signed [Y_W-1:0] TOP_WIDE   = Y_W'(65535);
    localparam logic signed [Y_W-1:0] TOP_NARROW = Y_W'(255);

    // configuration
    logic [INC_W-1:0] r_inc;
    logic [AMP_W-1:0] r_amp;
    logic [1:0]       r_wave;
    logic [1:0]       r_res;
    logic [1:0]       r_interp;
    logic             w_res_clear;

    logic [PHASE_BITS-1:0] r_phase;

    // memories
    logic [7:0]         r_short_mem  [0:(4 << SIDX_BITS)-1];
    logic [7:0]         r_narrow_mem [0:(4 << IDX_BITS)-1];
    logic [VALUE_W-1:0] r_wide_mem   [0:(4 << IDX_BITS)-1];
    logic [7:0]         r_short_rd;
    logic [7:0]         r_narrow_rd;
    logic [VALUE_W-1:0] r_wide_rd;

    // addressing
    logic [IDX_BITS-1:0]         w_top;
    logic [IDX_BITS-1:0]         w_idx;
    logic [SIDX_BITS-1:0]        w_stop;
    logic [SIDX_BITS-1:0]        w_sidx;
    logic [IDX_BITS:0]           w_rd_sum;
    logic [IDX_BITS-1:0]         w_rd_pos;
    logic [PHASE_BITS+F-1:0]     w_phase_ext;
    logic [F-1:0]                w_frac;
    logic [IDX_BITS-1:0]         w_wr_pos;
    logic [SIDX_BITS-1:0]        w_wr_spos;
    logic                        w_wr_short;
    logic                        w_wr_narrow;
    logic                        w_wr_wide;
    logic [VALUE_W-1:0]          w_rd_data;

    // arithmetic
    logic [VALUE_W-1:0]          r_p0;
    logic [VALUE_W-1:0]          r_p1;
    logic [VALUE_W-1:0]          r_p2;
    logic signed [P_W-1:0]       w_d1;
    logic signed [D2_W-1:0]      w_d2;
    logic signed [M1_W-1:0]      r_m1;
    logic signed [M2_W-1:0]      r_m2;
    logic [F-1:0]                r_t2;
    logic [2*F-1:0]              w_tt;
    logic signed [Y_W-1:0]       w_lin;
    logic signed [Y_W-1:0]       w_quad;
    logic signed [Y_W-1:0]       w_top_val;
    logic [VALUE_W-1:0]          n_value;
    logic [VALUE_W-1:0]          r_value;
    logic [VALUE_W+AMP_W-1:0]    w_scaled;

    logic                        r_out_valid;
    logic [SAMPLE_W-1:0]         r_sample;

    // ---------------------------------------------------------------- config
    assign w_res_clear = i_cmd.cfg_write && (i_cfg_index == REG_RES_MODE)
                         && (i_cfg_data[1:0] inside {RES_SHORT, RES_NARROW, RES_WIDE});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc    <= '0;
            r_amp    <= '1;
            r_wave   <= '0;
            r_res    <= RES_SHORT;
            r_interp <= INTERP_OFF;
        end else if (i_cmd.cfg_write) begin
            case (i_cfg_index)
                REG_PHASE_INC: r_inc  <= i_cfg_data[INC_W-1:0];
                REG_AMPLITUDE: r_amp  <= i_cfg_data[AMP_W-1:0];
                REG_WAVEFORM:  r_wave <= i_cfg_data[1:0];
                REG_RES_MODE: begin
                    if (w_res_clear) begin
                        r_res <= i_cfg_data[1:0];
                    end
                end
                REG_INTERP: begin
                    if (i_cfg_data[1:0] inside {INTERP_OFF, INTERP_LIN, INTERP_QUAD}) begin
                        r_interp <= i_cfg_data[1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (w_res_clear || i_cmd.clear_phase) begin
            r_phase <= '0;
        end else if (i_cmd.step) begin
            r_phase <= r_phase + PHASE_BITS'(r_inc);
        end
    end

    // table position from the top phase bits, folded once into the depth
    assign w_top  = r_phase[PHASE_BITS-1 -: IDX_BITS];
    assign w_idx  = ({1'b0, w_top} >= DEPTH_L) ? IDX_BITS'({1'b0, w_top} - DEPTH_L)
                                                : w_top;
    assign w_stop = r_phase[PHASE_BITS-1 -: SIDX_BITS];
    assign w_sidx = ({1'b0, w_stop} >= SDEPTH_L) ? SIDX_BITS'({1'b0, w_stop} - SDEPTH_L)
                                                  : w_stop;

    assign w_rd_sum = {1'b0, w_idx} + (IDX_BITS + 1)'(i_cmd.rd_off);
    assign w_rd_pos = (w_rd_sum >= DEPTH_L) ? IDX_BITS'(w_rd_sum - DEPTH_L)
                                            : IDX_BITS'(w_rd_sum);

    assign w_phase_ext = {r_phase, F'(0)};
    assign w_frac      = w_phase_ext[PHASE_BITS-IDX_BITS +: F];

    // ---------------------------------------------------------------- tables
    assign w_wr_pos    = IDX_BITS'(i_entry_index);
    assign w_wr_spos   = SIDX_BITS'(i_entry_index);
    assign w_wr_short  = i_cmd.write_entry && (i_table_kind == RES_SHORT)
                         && (32'(i_entry_index) < SHORT_TABLE_DEPTH);
    assign w_wr_narrow = i_cmd.write_entry && (i_table_kind == RES_NARROW)
                         && (32'(i_entry_index) < TABLE_DEPTH);
    assign w_wr_wide   = i_cmd.write_entry && (i_table_kind == RES_WIDE)
                         && (32'(i_entry_index) < TABLE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (w_wr_short) begin
            r_short_mem[{i_wave_index, w_wr_spos}] <= i_entry_value[7:0];
        end
        r_short_rd <= r_short_mem[{r_wave, w_sidx}];
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_narrow) begin
            r_narrow_mem[{i_wave_index, w_wr_pos}] <= i_entry_value[7:0];
        end
        r_narrow_rd <= r_narrow_mem[{r_wave, w_rd_pos}];
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_wide) begin
            r_wide_mem[{i_wave_index, w_wr_pos}] <= i_entry_value;
        end
        r_wide_rd <= r_wide_mem[{r_wave, w_rd_pos}];
    end

    always_comb begin
        case (r_res)
            RES_SHORT:  w_rd_data = VALUE_W'(r_short_rd);
            RES_NARROW: w_rd_data = VALUE_W'(r_narrow_rd);
            default:    w_rd_data = r_wide_rd;
        endcase
    end

    // ---------------------------------------------------------------- maths
    assign w_d1 = (r_interp == INTERP_QUAD)
                  ? $signed({1'b0, r_p2}) - $signed({1'b0, r_p0})
                  : $signed({1'b0, r_p1}) - $signed({1'b0, r_p0});
    assign w_d2 = $signed({2'b00, r_p0}) - $signed({1'b0, r_p1, 1'b0})
                  + $signed({2'b00, r_p2});
    assign w_tt = w_frac * w_frac;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_p0) begin
            r_p0 <= w_rd_data;
        end
        if (i_cmd.cap_p1) begin
            r_p1 <= w_rd_data;
        end
        if (i_cmd.cap_p2) begin
            r_p2 <= w_rd_data;
        end
        if (i_cmd.mul1) begin
            r_m1 <= w_d1 * $signed({1'b0, w_frac});
            r_t2 <= w_tt[2*F-1:F];
        end
        if (i_cmd.mul2) begin
            r_m2 <= w_d2 * $signed({1'b0, r_t2});
        end
        if (i_cmd.sum) begin
            r_value <= n_value;
        end
    end

    // arithmetic shifts give the floor of the division
    assign w_lin     = $signed({4'b0000, r_p0}) + Y_W'(r_m1 >>> F);
    assign w_quad    = $signed({4'b0000, r_p1}) + Y_W'(r_m1 >>> (F + 1))
                       + Y_W'(r_m2 >>> (F + 1));
    assign w_top_val = (r_res == RES_WIDE) ? TOP_WIDE : TOP_NARROW;

    always_comb begin
        n_value = r_p0;
        if (r_res != RES_SHORT) begin
            case (r_interp)
                INTERP_LIN: n_value = VALUE_W'(w_lin);
                INTERP_QUAD: begin
                    if (w_quad < 0) begin
                        n_value = '0;
                    end else if (w_quad > w_top_val) begin
                        n_value = VALUE_W'(w_top_val);
                    end else begin
                        n_value = VALUE_W'(w_quad);
                    end
                end
                default: n_value = r_p0;
            endcase
        end
    end

    assign w_scaled = r_value * r_amp;

    // ---------------------------------------------------------------- output
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_sample <= w_scaled[VALUE_W+AMP_W-1 -: SAMPLE_W];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;

endmodule
`default_nettype wire

>>> sv/dds_waveform_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dds_waveform_generator
// Phase-accumulator waveform generator with loadable wave tables, optional
// linear or quadratic interpolation and amplitude scaling.
//
//   channel  direction  handshake                 payload
//   in       sink       i_in_valid / o_in_ready   operation, table_kind,
//                                                 wave_index, entry_index,
//                                                 entry_value
//   out      source     o_out_valid / i_out_ready sample
//   cfg      sink       i_cfg_valid / o_cfg_ready cfg_index, cfg_data
//
// Write and clear items leave the sequencer in its idle state; a waiting register
// write holds items off. A sample item walks the states RD0 to RD3, MUL1, MUL2,
// SUM and SCALE before the next item can be taken: three reads through the one
// read port of each table memory, two multiply steps, a sum and the scaling.
// Reset is synchronous and active low; tables are not cleared by reset.
// A finished sample waits in the output register while the next item is
// taken; only a second sample stalls in its last step until that is drained.
// ----------------------------------------------------------------------------
module dds_waveform_generator #(
    parameter int TABLE_DEPTH       = dds_pkg::DEF_TABLE_DEPTH,
    parameter int SHORT_TABLE_DEPTH = dds_pkg::DEF_SHORT_TABLE_DEPTH,
    parameter int FRACTION_BITS     = dds_pkg::DEF_FRACTION_BITS,
    parameter int PHASE_BITS        = dds_pkg::DEF_PHASE_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [1:0]                       i_operation,
    input  logic [1:0]                       i_table_kind,
    input  logic [1:0]                       i_wave_index,
    input  logic [dds_pkg::ENTRY_W-1:0]      i_entry_index,
    input  logic [dds_pkg::VALUE_W-1:0]      i_entry_value,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [dds_pkg::SAMPLE_W-1:0]     o_sample,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [dds_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dds_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import dds_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    dds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    dds_dp #(
        .TABLE_DEPTH       (TABLE_DEPTH),
        .SHORT_TABLE_DEPTH (SHORT_TABLE_DEPTH),
        .FRACTION_BITS     (FRACTION_BITS),
        .PHASE_BITS        (PHASE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_table_kind  (i_table_kind),
        .i_wave_index  (i_wave_index),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_sample      (o_sample)
    );

endmodule
`default_nettype wire
